@@ hdl/sus_pkg.sv @@
// ----------------------------------------------------------------------------
// sus_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package sus_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_WIDTH = 32;

	// index into the key store and a count that can also hold CAPACITY
	localparam int POS_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// result field widths on the stream
	localparam int POS_FIELD_W = 4;
	localparam int CNT_FIELD_W = 5;
	localparam int OUT_BITS    = 2 + POS_FIELD_W + CNT_FIELD_W + 1;
	localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_MISS = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture a new item, rewind the scan index
		logic scan_next; // advance the scan
		logic mark;      // latch the lower-bound position and the match flag
		logic settle;    // latch the result code and position
		logic up_init;   // start opening a gap from the top
		logic up_step;   // move one key up
		logic up_put;    // drop the new key into the gap
		logic dn_init;   // start closing the gap at the match
		logic dn_step;   // move one key down
		logic dn_drop;   // shrink the set
		logic emit;      // load the output register
	} sus_cmd_t;

	// datapath -> controller
	typedef struct packed {
		func_t func;
		logic  scan_stop;
		logic  hit;
		logic  full;
		logic  up_more;
		logic  dn_more;
		logic  out_free;
	} sus_stat_t;

endpackage

`default_nettype wire

@@ hdl/sus_datapath.sv @@
// ----------------------------------------------------------------------------
// sus_datapath
// key store, count, scan index, compare and output register
// ----------------------------------------------------------------------------
`default_nettype none

module sus_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [31:0]                     s_tdata,
	input  wire logic [1:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [sus_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  wire sus_pkg::sus_cmd_t               cmd,
	output sus_pkg::sus_stat_t                   stat
);
	import sus_pkg::*;

	logic signed [KEY_WIDTH-1:0] keys_q [CAPACITY];
	logic signed [KEY_WIDTH-1:0] key_q;
	func_t                       func_q;
	logic        [CNT_W-1:0]     count_q;
	logic        [CNT_W-1:0]     idx_q;
	logic        [CNT_W-1:0]     at_q;
	logic                        hit_q;
	status_t                     res_status_q;
	logic        [POS_W-1:0]     res_pos_q;
	logic                        m_tvalid_q;
	logic        [OUT_DATA_W-1:0] m_tdata_q;

	logic        [CNT_W-1:0]     rd_idx;
	logic signed [KEY_WIDTH-1:0] rd_key;
	logic signed [KEY_WIDTH-1:0] scan_key;
	logic        [CNT_W:0]       idx_inc;
	logic                        at_end;
	status_t                     nxt_status;
	logic        [POS_W-1:0]     nxt_pos;

	// shift read: shifting up reads below idx, shifting down reads above
	always_comb begin
		if (cmd.up_step) begin
			rd_idx = idx_q - CNT_W'(1);
		end else if (cmd.dn_step) begin
			rd_idx = idx_q + CNT_W'(1);
		end else begin
			rd_idx = idx_q;
		end
	end

	assign rd_key   = keys_q[rd_idx[POS_W-1:0]];
	// scan compare reads at the scan index, independent of the commands
	assign scan_key = keys_q[idx_q[POS_W-1:0]];
	assign idx_inc  = {1'b0, idx_q} + (CNT_W+1)'(1);
	assign at_end   = (idx_q == count_q);

	assign stat.func      = func_q;
	assign stat.scan_stop = at_end || (scan_key >= key_q);
	assign stat.hit       = hit_q;
	assign stat.full      = (count_q == CNT_W'(CAPACITY));
	assign stat.up_more   = (idx_q > at_q);
	assign stat.dn_more   = (idx_inc < {1'b0, count_q});
	assign stat.out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		nxt_status = ST_OK;
		nxt_pos    = '0;
		unique case (func_q)
			FUNC_INSERT: begin
				if (hit_q) begin
					nxt_status = ST_DUP;
					nxt_pos    = at_q[POS_W-1:0];
				end else if (stat.full) begin
					nxt_status = ST_FULL;
				end else begin
					nxt_pos = at_q[POS_W-1:0];
				end
			end
			FUNC_DELETE, FUNC_LOOKUP: begin
				if (hit_q) begin
					nxt_pos = at_q[POS_W-1:0];
				end else begin
					nxt_status = ST_MISS;
				end
			end
			FUNC_NONE: begin
				nxt_status = ST_OK;
			end
			default: begin
				nxt_status = ST_OK;
			end
		endcase
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= s_tdata[KEY_WIDTH-1:0];
			func_q <= func_t'(s_tuser);
		end
		if (cmd.mark) begin
			at_q  <= idx_q;
			hit_q <= !at_end && (scan_key == key_q);
		end
		if (cmd.settle) begin
			res_status_q <= nxt_status;
			res_pos_q    <= nxt_pos;
		end
		if (cmd.up_step || cmd.dn_step) begin
			keys_q[idx_q[POS_W-1:0]] <= rd_key;
		end
		if (cmd.up_put) begin
			keys_q[at_q[POS_W-1:0]] <= key_q;
		end
		if (cmd.emit) begin
			m_tdata_q <= OUT_DATA_W'({
				(count_q == '0),
				CNT_FIELD_W'(count_q),
				POS_FIELD_W'(res_pos_q),
				res_status_q
			});
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan_next || cmd.dn_step) begin
				idx_q <= idx_inc[CNT_W-1:0];
			end else if (cmd.up_init) begin
				idx_q <= count_q;
			end else if (cmd.up_step) begin
				idx_q <= idx_q - CNT_W'(1);
			end else if (cmd.dn_init) begin
				idx_q <= at_q;
			end
			if (cmd.up_put) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.dn_drop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("key count above capacity");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid_q || m_tready))
		else $error("result overwrites one not yet taken");

	a_up_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.up_step |-> (idx_q > at_q) && (idx_q < CNT_W'(CAPACITY)))
		else $error("shift up outside the open gap");

	a_drop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dn_drop |-> (count_q != '0) && hit_q)
		else $error("delete without a held match");

	a_put_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.up_put |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the set");

endmodule

`default_nettype wire

@@ hdl/sus_controller.sv @@
// ----------------------------------------------------------------------------
// sus_controller
// sequencer: scan, decide, shift, deliver
// ----------------------------------------------------------------------------
`default_nettype none

module sus_controller (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire sus_pkg::sus_stat_t stat,
	output sus_pkg::sus_cmd_t       cmd
);
	import sus_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		SCAN,
		DECIDE,
		SHIFT_UP,
		SHIFT_DN,
		FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = SCAN;
				end
			end
			SCAN: begin
				if (stat.scan_stop) begin
					cmd.mark = 1'b1;
					state_d  = DECIDE;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			DECIDE: begin
				cmd.settle = 1'b1;
				if (stat.func == FUNC_INSERT && !stat.hit && !stat.full) begin
					cmd.up_init = 1'b1;
					state_d     = SHIFT_UP;
				end else if (stat.func == FUNC_DELETE && stat.hit) begin
					cmd.dn_init = 1'b1;
					state_d     = SHIFT_DN;
				end else begin
					state_d = FINISH;
				end
			end
			SHIFT_UP: begin
				if (stat.up_more) begin
					cmd.up_step = 1'b1;
				end else begin
					cmd.up_put = 1'b1;
					state_d    = FINISH;
				end
			end
			SHIFT_DN: begin
				if (stat.dn_more) begin
					cmd.dn_step = 1'b1;
				end else begin
					cmd.dn_drop = 1'b1;
					state_d     = FINISH;
				end
			end
			FINISH: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == IDLE) && s_tvalid)
		else $error("item taken outside idle");

	a_emit_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (state_q == IDLE))
		else $error("sequencer did not return to idle after a result");

	a_scan_to_decide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark |=> (state_q == DECIDE))
		else $error("scan end not followed by decision");

endmodule

`default_nettype wire

@@ hdl/sorted_unique_set_core.sv @@
// ----------------------------------------------------------------------------
// sorted_unique_set_core
// ordered set of up to 16 distinct signed 32-bit keys
// ----------------------------------------------------------------------------
// Each item on the slave stream is one request: insert, delete or look up a
// key (tuser selects the operation, tdata carries the key). Keys are held in
// ascending signed order. Every request yields exactly one item on the master
// stream with a status code (ok, duplicate, not found, full), the position of
// the matched or inserted key, the key count after the request and an empty
// flag. One request is worked on at a time. The sequencer scans linearly from
// position 0 to the first key not below the request (one entry per cycle),
// then moves keys one position per cycle to open or close a gap. Its result is
// loaded once the output register is free, and the sequencer then returns to
// idle to take the next request. The linear scan and the one-key-per-cycle
// shift set the time a request takes. A finished result sits in an output
// register, and the next request is accepted while it waits to be taken. The
// key store itself is not cleared by reset; only positions below the count
// are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [31:0]                    s_tdata,  // [31:0] key_value
	input  wire logic [1:0]                     s_tuser,  // [1:0] func
	// result stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [1:0] status, [5:2] found_position, [10:6] entry_count, [11] is_empty
	output logic      [sus_pkg::OUT_DATA_W-1:0] m_tdata
);
	import sus_pkg::*;

	sus_cmd_t  cmd;
	sus_stat_t stat;

	// state machine that steps through scan, decision and shifting
	sus_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// key store, compare logic and result register
	sus_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

`default_nettype wire

@@ test/sorted_unique_set_core_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_unique_set_core_tb
// self-checking bench for the ordered set of distinct signed keys
// ----------------------------------------------------------------------------
// Requests go in on the slave stream and results come back on the master
// stream. A behavioral copy of the set runs beside the block. Each accepted
// request is applied to that copy and the result it gives is queued. Each
// result taken from the block is compared field by field with the oldest
// queued one. A short table of requests comes first. It covers the empty set,
// the extreme keys, a hit at the first position, a full set, a duplicate on a
// full set and the unused operation code. Random requests over a small key
// pool follow, so the set fills, drains and hits often. They run through
// several idle and stall mixes and one long back-pressure stretch.
// ----------------------------------------------------------------------------

module sorted_unique_set_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sus_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int PHASE_ITEMS   = 370;
	localparam int SQUEEZE_ITEMS = 60;
	localparam int SQUEEZE_HOLD  = 300;
	localparam int DRAIN_CYCLES  = 40;
	localparam int POOL_SIZE     = 20;
	localparam int MAX_REPORTS   = 10;

	// one result item as the block packs it, lowest field last here
	typedef struct packed {
		logic       empty;
		logic [4:0] count;
		logic [3:0] pos;
		status_t    status;
	} set_result_t;

	// one row of the directed table; want is only used when typed is set
	typedef struct packed {
		func_t       op;
		logic [31:0] key;
		logic        typed;
		set_result_t want;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata = '0;   // [31:0] key_value
	logic [1:0]            s_tuser = '0;   // [1:0] func
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [1:0] status, [5:2] found_position, [10:6] entry_count, [11] is_empty
	logic [OUT_DATA_W-1:0] m_tdata;

	// behavioral copy of the set
	logic signed [31:0] held_keys [CAPACITY];
	int                 held_count = 0;

	set_result_t awaited_replies [$];

	int error_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int ops_taken [4] = '{default: 0};
	int status_seen [4] = '{default: 0};
	int full_results = 0;
	int empty_results = 0;

	logic [31:0] key_pool [POOL_SIZE];

	sorted_unique_set_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// directed table: empty set, extremes, hit at position 0, filling to
	// capacity, full and duplicate-on-full, unused operation code
	directed_row_t directed_rows [0:26] = '{
		'{FUNC_LOOKUP, 32'h0000_0000, 1'b1, '{1'b1, 5'd0, 4'd0, ST_MISS}},
		'{FUNC_DELETE, 32'h0000_0005, 1'b1, '{1'b1, 5'd0, 4'd0, ST_MISS}},
		'{FUNC_NONE,   32'h0000_0000, 1'b1, '{1'b1, 5'd0, 4'd0, ST_OK}},
		'{FUNC_INSERT, 32'h8000_0000, 1'b1, '{1'b0, 5'd1, 4'd0, ST_OK}},
		'{FUNC_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b0, 5'd2, 4'd1, ST_OK}},
		'{FUNC_INSERT, 32'h8000_0000, 1'b1, '{1'b0, 5'd2, 4'd0, ST_DUP}},
		'{FUNC_LOOKUP, 32'h8000_0000, 1'b1, '{1'b0, 5'd2, 4'd0, ST_OK}},
		'{FUNC_INSERT, 32'h0000_0000, 1'b0, '0},
		'{FUNC_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
		'{FUNC_INSERT, 32'h5555_5555, 1'b0, '0},
		'{FUNC_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
		'{FUNC_INSERT, 32'h0000_0001, 1'b0, '0},
		'{FUNC_INSERT, 32'h7FFF_FFFE, 1'b0, '0},
		'{FUNC_INSERT, 32'h8000_0001, 1'b0, '0},
		'{FUNC_INSERT, 32'h0F0F_0F0F, 1'b0, '0},
		'{FUNC_INSERT, 32'hF0F0_F0F0, 1'b0, '0},
		'{FUNC_INSERT, 32'h1234_5678, 1'b0, '0},
		'{FUNC_INSERT, 32'hEDCB_A987, 1'b0, '0},
		'{FUNC_INSERT, 32'h0000_0064, 1'b0, '0},
		'{FUNC_INSERT, 32'hFFFF_FF9C, 1'b0, '0},
		'{FUNC_INSERT, 32'h3333_3333, 1'b0, '0},
		'{FUNC_INSERT, 32'h0000_0007, 1'b1, '{1'b0, 5'd16, 4'd0, ST_FULL}},
		'{FUNC_INSERT, 32'h0000_0000, 1'b0, '0},
		'{FUNC_LOOKUP, 32'h0000_0007, 1'b0, '0},
		'{FUNC_LOOKUP, 32'h7FFF_FFFF, 1'b1, '{1'b0, 5'd16, 4'd15, ST_OK}},
		'{FUNC_DELETE, 32'h8000_0000, 1'b1, '{1'b0, 5'd15, 4'd0, ST_OK}},
		'{FUNC_NONE,   32'hFFFF_FFFF, 1'b0, '0}
	};

	// apply one request to the behavioral set and give the result it causes
	function automatic set_result_t apply_set_request(func_t op, logic signed [31:0] key);
		set_result_t res;
		int          at;
		logic        hit;
		at = 0;
		while (at < held_count && held_keys[at] < key)
			at++;
		hit = (at < held_count) && (held_keys[at] == key);
		res.status = ST_OK;
		res.pos    = '0;
		case (op)
			FUNC_INSERT: begin
				if (hit) begin
					// duplicates win over a full set
					res.status = ST_DUP;
					res.pos    = 4'(at);
				end else if (held_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (int i = held_count; i > at; i--)
						held_keys[i] = held_keys[i - 1];
					held_keys[at] = key;
					held_count++;
					res.pos = 4'(at);
				end
			end
			FUNC_DELETE: begin
				if (hit) begin
					for (int i = at; i + 1 < held_count; i++)
						held_keys[i] = held_keys[i + 1];
					held_count--;
					res.pos = 4'(at);
				end else begin
					res.status = ST_MISS;
				end
			end
			FUNC_LOOKUP: begin
				if (hit)
					res.pos = 4'(at);
				else
					res.status = ST_MISS;
			end
			default: begin
				// unused code leaves the set alone
			end
		endcase
		res.count = 5'(held_count);
		res.empty = (held_count == 0);
		return res;
	endfunction

	task automatic note_failure(string what);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// drive one request from a falling edge, wait for the handshake, then
	// queue what it should produce; returns on the next falling edge
	task automatic offer_request(func_t op, logic [31:0] key, logic typed, set_result_t want);
		set_result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = key;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = apply_set_request(op, key);
		awaited_replies.push_back(typed ? want : predicted);
		ops_taken[op]++;
		@(negedge clk);
	endtask

	// keys mostly from a pool a bit larger than the set, so hits and a full
	// set are common; extremes always in the pool
	task automatic refresh_pool();
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
	endtask

	function automatic logic [31:0] draw_key();
		if ($urandom_range(99) < 10)
			return $urandom;
		return key_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	// receiver: random stalls, plus a long hold-off when the sender asks
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = SQUEEZE_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			m_tready = ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		set_result_t got;
		set_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = status_t'(m_tdata[1:0]);
			got.pos    = m_tdata[5:2];
			got.count  = m_tdata[10:6];
			got.empty  = m_tdata[11];
			status_seen[got.status]++;
			if (got.count == 5'(CAPACITY))
				full_results++;
			if (got.empty)
				empty_results++;
			if (awaited_replies.size() == 0) begin
				note_failure($sformatf("result with none expected: status %0d pos %0d count %0d empty %0b",
					got.status, got.pos, got.count, got.empty));
			end else begin
				want = awaited_replies.pop_front();
				if (got.status !== want.status)
					note_failure($sformatf("status expected %0d got %0d", want.status, got.status));
				if (got.pos !== want.pos)
					note_failure($sformatf("found_position expected %0d got %0d", want.pos, got.pos));
				if (got.count !== want.count)
					note_failure($sformatf("entry_count expected %0d got %0d", want.count, got.count));
				if (got.empty !== want.empty)
					note_failure($sformatf("is_empty expected %0b got %0b", want.empty, got.empty));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_replies.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int    ins_lim;
		int    del_lim;
		int    look_lim;
		int    pick;
		func_t op;

		// reset, released on a falling edge
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			offer_request(directed_rows[i].op, directed_rows[i].key,
				directed_rows[i].typed, directed_rows[i].want);

		// random part: no idling, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
				default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
			endcase
			refresh_pool();
			ins_lim  = 40;
			del_lim  = 65;
			look_lim = 95;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// switch between filling, draining and mixed bursts
				if (n % 40 == 0) begin
					case ($urandom_range(2))
						0: begin ins_lim = 70; del_lim = 80; look_lim = 95; end
						1: begin ins_lim = 15; del_lim = 75; look_lim = 95; end
						default: begin ins_lim = 40; del_lim = 65; look_lim = 95; end
					endcase
				end
				pick = $urandom_range(99);
				if (pick < ins_lim)
					op = FUNC_INSERT;
				else if (pick < del_lim)
					op = FUNC_DELETE;
				else if (pick < look_lim)
					op = FUNC_LOOKUP;
				else
					op = FUNC_NONE;
				offer_request(op, draw_key(), 1'b0, '0);
			end
		end

		// back-pressure: receiver holds off while requests keep coming
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_requests++;
		for (int n = 0; n < SQUEEZE_ITEMS; n++) begin
			pick = $urandom_range(99);
			op = (pick < 50) ? FUNC_INSERT : (pick < 75) ? FUNC_LOOKUP : FUNC_DELETE;
			offer_request(op, draw_key(), 1'b0, '0);
		end
		s_tvalid = 1'b0;

		// drain, then give any stray result time to show up
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("requests: %0d insert, %0d delete, %0d lookup, %0d unused code",
			ops_taken[FUNC_INSERT], ops_taken[FUNC_DELETE],
			ops_taken[FUNC_LOOKUP], ops_taken[FUNC_NONE]);
		$display("results: %0d ok, %0d duplicate, %0d miss, %0d full; set full %0d, empty %0d times",
			status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_MISS],
			status_seen[ST_FULL], full_results, empty_results);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
